FILE: src/lppq_pkg.sv
// Shared types, sizes and address helpers for the length-prefixed packet queue.
// Used by every module under src except lppq_ram; depends on nothing.
`timescale 1ns / 1ps

package lppq_pkg;

    localparam int QUEUE_BYTES = 256;
    localparam int QUEUE_COUNT = 3;
    localparam int PW          = $clog2(QUEUE_BYTES);
    localparam int CW          = $clog2(QUEUE_BYTES + 1);
    localparam int RAM_DEPTH   = QUEUE_COUNT * QUEUE_BYTES;
    localparam int AW          = $clog2(RAM_DEPTH);
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic       first;
        logic [7:0] dbyte;
        logic [7:0] plen;
        logic [1:0] qsel;
        logic       mode;
    } item_t;

    function automatic logic [AW-1:0] ram_addr(input logic [1:0] q, input logic [PW-1:0] pos);
        ram_addr = AW'(AW'(q) * AW'(QUEUE_BYTES)) + AW'(pos);
    endfunction

    // position modulo the queue size, valid for x below twice the size
    function automatic logic [PW-1:0] wrap_pos(input logic [CW:0] x);
        if (x >= (CW+1)'(QUEUE_BYTES))
            wrap_pos = PW'(x - (CW+1)'(QUEUE_BYTES));
        else
            wrap_pos = PW'(x);
    endfunction

endpackage

FILE: src/lppq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module lppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/lppq_front.sv
// Front end: accepts input words, unpacks them and holds them in a short queue.
// Depends on lppq_pkg.
`timescale 1ns / 1ps

module lppq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // packet_length, data_byte
    input  logic [3:0]          s_axis_tuser,  // mode, queue_select[1:0], byte_first
    output lppq_pkg::item_t     item,
    output logic                item_valid,
    input  logic                item_pop
);

    lppq_pkg::item_t                   slot_reg [lppq_pkg::FIFO_DEPTH];
    logic [lppq_pkg::FIFO_PW-1:0]      wr_reg;
    logic [lppq_pkg::FIFO_PW-1:0]      rd_reg;
    logic [lppq_pkg::FIFO_CW-1:0]      cnt_reg;
    lppq_pkg::item_t                   in_item;
    logic                              push;
    logic                              pop;

    assign in_item.mode  = s_axis_tuser[0];
    assign in_item.qsel  = s_axis_tuser[2:1];
    assign in_item.first = s_axis_tuser[3];
    assign in_item.plen  = s_axis_tdata[7:0];
    assign in_item.dbyte = s_axis_tdata[15:8];

    assign s_axis_tready = (cnt_reg != lppq_pkg::FIFO_CW'(lppq_pkg::FIFO_DEPTH));
    assign item_valid    = (cnt_reg != '0);
    assign item          = slot_reg[rd_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_pop && item_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == lppq_pkg::FIFO_PW'(lppq_pkg::FIFO_DEPTH - 1)) ?
                          '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == lppq_pkg::FIFO_PW'(lppq_pkg::FIFO_DEPTH - 1)) ?
                          '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/lppq_back.sv
// Back end: sequencer that runs one queued word against the queue state and store,
// with the result held in an output register. Depends on lppq_pkg and lppq_ram.
`timescale 1ns / 1ps

module lppq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lppq_pkg::item_t     item,
    input  logic                item_valid,
    output logic                item_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,  // read_byte, occupancy, dropped_packets
    output logic                m_axis_tlast,  // packet_end
    output logic [1:0]          m_axis_tuser   // queue_empty, rejected
);

    localparam int PW = lppq_pkg::PW;
    localparam int CW = lppq_pkg::CW;
    localparam int AW = lppq_pkg::AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVCHK = 3'd1;
    localparam logic [2:0] S_EVRD  = 3'd2;
    localparam logic [2:0] S_WRDAT = 3'd3;
    localparam logic [2:0] S_DQLEN = 3'd4;
    localparam logic [2:0] S_DQBYT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]       st_reg, st_next;
    lppq_pkg::item_t  it_reg, it_next;
    logic [7:0]       len_reg, len_next;
    logic [CW-1:0]    drop_reg, drop_next;
    logic [7:0]       rbyte_reg, rbyte_next;
    logic             pend_reg, pend_next;
    logic             empty_reg, empty_next;
    logic             rej_reg, rej_next;

    logic             ov_reg, ov_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic [CW-1:0]    oocc_reg, oocc_next;
    logic [CW-1:0]    odrop_reg, odrop_next;
    logic             oend_reg, oend_next;
    logic             oempty_reg, oempty_next;
    logic             orej_reg, orej_next;

    logic [PW-1:0]    head_reg [lppq_pkg::QUEUE_COUNT];
    logic [CW-1:0]    comm_reg [lppq_pkg::QUEUE_COUNT];
    logic [CW-1:0]    pcnt_reg [lppq_pkg::QUEUE_COUNT];
    logic [PW-1:0]    roff_reg [lppq_pkg::QUEUE_COUNT];
    logic [7:0]       plen_reg [lppq_pkg::QUEUE_COUNT];

    lppq_pkg::item_t  cur;
    logic             q_ok;
    logic [PW-1:0]    h, h_next;
    logic [CW-1:0]    c, c_next;
    logic [CW-1:0]    p, p_next;
    logic [PW-1:0]    o, o_next;
    logic [7:0]       l, l_next;
    logic             sq_we;
    logic [PW-1:0]    tail;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    // bytes freed when the head packet of length len goes
    function automatic logic [CW-1:0] head_size(input logic [7:0] len, input logic [CW-1:0] cnt);
        logic [CW:0] full;
        full = (CW+1)'(len) + (CW+1)'(1);
        if (full > (CW+1)'(cnt))
            head_size = cnt;
        else
            head_size = CW'(full);
    endfunction

    lppq_ram #(
        .WIDTH (8),
        .DEPTH (lppq_pkg::RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur  = (st_reg == S_IDLE) ? item : it_reg;
    assign q_ok = (32'(cur.qsel) < lppq_pkg::QUEUE_COUNT);
    assign h    = head_reg[cur.qsel];
    assign c    = comm_reg[cur.qsel];
    assign p    = pcnt_reg[cur.qsel];
    assign o    = roff_reg[cur.qsel];
    assign l    = plen_reg[cur.qsel];
    assign tail = lppq_pkg::wrap_pos((CW+1)'(h) + (CW+1)'(c));

    always_comb
    begin
        logic [CW-1:0] sz;
        logic [CW:0]   need;
        logic [CW:0]   p1;
        logic [PW:0]   o1;

        st_next    = st_reg;
        it_next    = it_reg;
        len_next   = len_reg;
        drop_next  = drop_reg;
        rbyte_next = rbyte_reg;
        pend_next  = pend_reg;
        empty_next = empty_reg;
        rej_next   = rej_reg;
        h_next     = h;
        c_next     = c;
        p_next     = p;
        o_next     = o;
        l_next     = l;
        sq_we      = 1'b0;
        item_pop   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = lppq_pkg::ram_addr(cur.qsel, tail);
        ram_wdata  = cur.plen;
        ram_raddr  = lppq_pkg::ram_addr(cur.qsel, h);
        sz         = '0;
        need       = (CW+1)'(c) + (CW+1)'(cur.plen) + (CW+1)'(1);
        p1         = (CW+1)'(p) + (CW+1)'(1);
        o1         = (PW+1)'(o) + (PW+1)'(1);

        ov_next    = ov_reg && !m_axis_tready;
        obyte_next = obyte_reg;
        oocc_next  = oocc_reg;
        odrop_next = odrop_reg;
        oend_next  = oend_reg;
        oempty_next = oempty_reg;
        orej_next  = orej_reg;

        case (st_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    it_next    = item;
                    drop_next  = '0;
                    rbyte_next = '0;
                    pend_next  = 1'b0;
                    empty_next = 1'b0;
                    rej_next   = 1'b0;
                    st_next    = S_OUT;
                    if (q_ok)
                    begin
                        if (item.mode == lppq_pkg::MODE_ENQ)
                        begin
                            if (item.first)
                            begin
                                p_next = '0;
                                sq_we  = 1'b1;
                                if (32'(item.plen) > lppq_pkg::QUEUE_BYTES - 1)
                                begin
                                    rej_next = 1'b1;
                                end
                                else
                                begin
                                    st_next = S_EVCHK;
                                end
                            end
                            else if (p != '0)
                            begin
                                // append at tail + pending, commit on the last byte
                                ram_we    = 1'b1;
                                ram_waddr = lppq_pkg::ram_addr(item.qsel,
                                    lppq_pkg::wrap_pos((CW+1)'(tail) + (CW+1)'(p)));
                                ram_wdata = item.dbyte;
                                sq_we     = 1'b1;
                                if (p1 >= (CW+1)'(l) + (CW+1)'(1))
                                begin
                                    c_next = CW'((CW+1)'(c) + (CW+1)'(l) + (CW+1)'(1));
                                    p_next = '0;
                                end
                                else
                                begin
                                    p_next = CW'(p1);
                                end
                            end
                        end
                        else
                        begin
                            if (c == '0)
                            begin
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                st_next = S_DQLEN;
                            end
                        end
                    end
                end
            end

            S_EVCHK:
            begin
                if (c != '0 && need > (CW+1)'(lppq_pkg::QUEUE_BYTES))
                begin
                    st_next = S_EVRD;
                end
                else
                begin
                    // write the length prefix
                    ram_we = 1'b1;
                    sq_we  = 1'b1;
                    l_next = cur.plen;
                    if (cur.plen != '0)
                    begin
                        p_next  = CW'(1);
                        st_next = S_WRDAT;
                    end
                    else
                    begin
                        c_next  = CW'((CW+1)'(c) + (CW+1)'(1));
                        p_next  = '0;
                        st_next = S_OUT;
                    end
                end
            end

            S_EVRD:
            begin
                // drop the oldest packet
                sz        = head_size(ram_rdata, c);
                h_next    = lppq_pkg::wrap_pos((CW+1)'(h) + (CW+1)'(sz));
                c_next    = c - sz;
                o_next    = '0;
                sq_we     = 1'b1;
                drop_next = drop_reg + 1'b1;
                st_next   = S_EVCHK;
            end

            S_WRDAT:
            begin
                ram_we    = 1'b1;
                ram_waddr = lppq_pkg::ram_addr(cur.qsel,
                    lppq_pkg::wrap_pos((CW+1)'(tail) + (CW+1)'(1)));
                ram_wdata = cur.dbyte;
                sq_we     = 1'b1;
                if (cur.plen == 8'd1)
                begin
                    c_next = CW'((CW+1)'(c) + (CW+1)'(2));
                    p_next = '0;
                end
                else
                begin
                    p_next = CW'(2);
                end
                st_next = S_OUT;
            end

            S_DQLEN:
            begin
                if (ram_rdata == '0)
                begin
                    pend_next = 1'b1;
                    sz        = head_size(ram_rdata, c);
                    h_next    = lppq_pkg::wrap_pos((CW+1)'(h) + (CW+1)'(sz));
                    c_next    = c - sz;
                    o_next    = '0;
                    sq_we     = 1'b1;
                    st_next   = S_OUT;
                end
                else
                begin
                    len_next  = ram_rdata;
                    ram_raddr = lppq_pkg::ram_addr(cur.qsel,
                        lppq_pkg::wrap_pos((CW+1)'(h) + (CW+1)'(o) + (CW+1)'(1)));
                    st_next   = S_DQBYT;
                end
            end

            S_DQBYT:
            begin
                rbyte_next = ram_rdata;
                sq_we      = 1'b1;
                if (o1 >= (PW+1)'(len_reg))
                begin
                    pend_next = 1'b1;
                    sz        = head_size(len_reg, c);
                    h_next    = lppq_pkg::wrap_pos((CW+1)'(h) + (CW+1)'(sz));
                    c_next    = c - sz;
                    o_next    = '0;
                end
                else
                begin
                    o_next = PW'(o1);
                end
                st_next = S_OUT;
            end

            S_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next     = 1'b1;
                    obyte_next  = rbyte_reg;
                    oocc_next   = q_ok ? c : '0;
                    odrop_next  = drop_reg;
                    oend_next   = pend_reg;
                    oempty_next = empty_reg;
                    orej_next   = rej_reg;
                    st_next     = S_IDLE;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            for (int i = 0; i < lppq_pkg::QUEUE_COUNT; i++)
            begin
                head_reg[i] <= '0;
                comm_reg[i] <= '0;
                pcnt_reg[i] <= '0;
                roff_reg[i] <= '0;
                plen_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            if (sq_we)
            begin
                head_reg[cur.qsel] <= h_next;
                comm_reg[cur.qsel] <= c_next;
                pcnt_reg[cur.qsel] <= p_next;
                roff_reg[cur.qsel] <= o_next;
                plen_reg[cur.qsel] <= l_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg     <= it_next;
        len_reg    <= len_next;
        drop_reg   <= drop_next;
        rbyte_reg  <= rbyte_next;
        pend_reg   <= pend_next;
        empty_reg  <= empty_next;
        rej_reg    <= rej_next;
        obyte_reg  <= obyte_next;
        oocc_reg   <= oocc_next;
        odrop_reg  <= odrop_next;
        oend_reg   <= oend_next;
        oempty_reg <= oempty_next;
        orej_reg   <= orej_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {(32 - 8 - 2*CW)'(0), odrop_reg, oocc_reg, obyte_reg};
    assign m_axis_tlast  = oend_reg;
    assign m_axis_tuser  = {orej_reg, oempty_reg};

endmodule

FILE: src/length_prefixed_packet_queue.sv
// Length-prefixed packet queues with drop-oldest admission: top level.
// Each input word passes through the front-end queue to the back-end sequencer, which runs it
// through its states (a dequeue reads the length prefix, then the byte; a first byte evicts the
// oldest packets as needed, then writes the prefix and any data byte) before registering the result
// word. The sequencer takes a new word only once the last result is in the output register.
// Reset (rst_n, async low) clears all pointers and counts; the store is not cleared.
`timescale 1ns / 1ps

module length_prefixed_packet_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // packet_length[7:0], data_byte[15:8]
    input  logic [3:0]  s_axis_tuser,  // mode[0], queue_select[2:1], byte_first[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_byte[7:0], occupancy[16:8], dropped_packets[25:17]
    output logic        m_axis_tlast,  // packet_end
    output logic [1:0]  m_axis_tuser   // queue_empty[0], rejected[1]
);

    lppq_pkg::item_t item;
    logic            item_valid;
    logic            item_pop;

    lppq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    lppq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
